// ===== src/buddy_page_allocator_macros.svh =====
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bpa_pkg.sv =====
package bpa_pkg;

	localparam int FRAME_BITS  = 16;
	localparam int LINK_BITS   = 17;
	localparam int ORDER_BITS  = 4;
	localparam int TYPE_BITS   = 2;
	localparam int COUNT_BITS  = 17;
	localparam int HEAD_COUNT  = 33;
	localparam int HEAD_BITS   = 6;
	localparam logic [ORDER_BITS-1:0] ORDER_COUNT = 4'd11;
	localparam logic [ORDER_BITS-1:0] ORDER_TOP   = 4'd10;
	localparam logic [TYPE_BITS-1:0]  TYPE_COUNT  = 2'd3;
	localparam logic [LINK_BITS-1:0]  NO_FRAME    = 17'h10000;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_OOM    = 2'd1,
		ST_DOUBLE = 2'd2,
		ST_BAD    = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_FREE_RD,
		S_FREE_CHK,
		S_OWN_RD,
		S_OWN_CHK,
		S_FB_RD,
		S_FB_CHK,
		S_SPLIT,
		S_MERGE_RD,
		S_MERGE_CHK,
		S_FREE_FIN,
		S_UN_RD,
		S_UN_DAT,
		S_UN_NEXT,
		S_UN_DROP,
		S_INS_RD,
		S_INS_CHK,
		S_INS_HRD,
		S_INS_HDAT,
		S_INS_LINK,
		S_DONE
	} bpa_state_t;

	typedef struct packed {
		logic                  free;
		logic [ORDER_BITS-1:0] order;
		logic [TYPE_BITS-1:0]  mtype;
		logic [LINK_BITS-1:0]  next;
		logic [LINK_BITS-1:0]  prev;
	} frame_word_t;

	typedef struct packed {
		logic free;
		logic order;
		logic mtype;
		logic next;
		logic prev;
	} frame_mask_t;

	function automatic logic [HEAD_BITS-1:0] head_index(input logic [ORDER_BITS-1:0] o,
		input logic [TYPE_BITS-1:0] t);
		logic [HEAD_BITS-1:0] base;
		base = {2'b00, o} + {1'b0, o, 1'b0};
		return base + {4'b0000, t};
	endfunction

	function automatic logic [TYPE_BITS-1:0] borrow_type(input logic [TYPE_BITS-1:0] t,
		input logic k);
		logic [TYPE_BITS-1:0] r;
		case (t)
			2'd0: r = k ? 2'd2 : 2'd1;
			2'd1: r = k ? 2'd2 : 2'd0;
			default: r = k ? 2'd0 : 2'd1;
		endcase
		return r;
	endfunction

endpackage

// ===== src/buddy_page_allocator.sv =====
// A request's time in the block depends on its path, from a rejected request, which goes straight to
// the result, up to an allocation borrowed at the top order and split down to order 0.
// Throughput: one word at a time; the frame memory, with one read and one write a cycle, sets the pace.
// The result register lets the next word be accepted while a result waits.
// Reset: arst_n clears all control state and list heads; a clearing pass
// then wipes the free marks in the frame memory, with in_stall held high.
module buddy_page_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               command,
	input  logic [bpa_pkg::ORDER_BITS-1:0]     block_order,
	input  logic [bpa_pkg::TYPE_BITS-1:0]      migrate_type,
	input  logic [bpa_pkg::FRAME_BITS-1:0]     frame_number,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [bpa_pkg::FRAME_BITS-1:0]     result_frame,
	output logic [bpa_pkg::ORDER_BITS-1:0]     result_order,
	output logic [bpa_pkg::COUNT_BITS-1:0]     free_page_count
);

	bpa_pkg::bpa_state_t state_q, nxt;
	bpa_pkg::bpa_state_t ret_u_q, ret_i_q;

	logic [bpa_pkg::ORDER_BITS-1:0]    ord_q, o_q, high_q, u_o_q, i_o_q;
	logic [bpa_pkg::TYPE_BITS-1:0]     typ_q, i_t_q;
	logic                              k_q;
	logic [bpa_pkg::FRAME_BITS-1:0]    f_q, pfn_q, b_q, u_f_q, i_f_q, clr_q;
	logic [bpa_pkg::LINK_BITS-1:0]     u_n_q, u_p_q, i_n_q;
	logic [bpa_pkg::COUNT_BITS-1:0]    total_q;
	bpa_pkg::status_t                  st_q;
	logic [bpa_pkg::FRAME_BITS-1:0]    rf_q;
	logic [bpa_pkg::ORDER_BITS-1:0]    ro_q;
	logic                              out_valid_q;
	logic [1:0]                        status_q;
	logic [bpa_pkg::FRAME_BITS-1:0]    result_frame_q;
	logic [bpa_pkg::ORDER_BITS-1:0]    result_order_q;
	logic [bpa_pkg::COUNT_BITS-1:0]    free_count_q;

	logic [bpa_pkg::FRAME_BITS-1:0]    fr_ra, fr_wa;
	bpa_pkg::frame_word_t              fr_rd, fr_wd;
	bpa_pkg::frame_mask_t              fr_wm;
	logic                              fr_we;
	logic [bpa_pkg::HEAD_BITS-1:0]     hd_ri, hd_wi;
	logic [bpa_pkg::LINK_BITS-1:0]     hd_rd, hd_wd;
	logic                              hd_we;

	logic                              in_take, bad_in, free_bad, load_out, found;
	logic [bpa_pkg::LINK_BITS-1:0]     size_in, split_b;
	logic [bpa_pkg::FRAME_BITS-1:0]    merge_b;
	logic [bpa_pkg::ORDER_BITS-1:0]    high_dn;

	bpa_frame_mem u_frame_mem (
		.clk     (clk),
		.rd_addr (fr_ra),
		.rd_data (fr_rd),
		.wr_en   (fr_we),
		.wr_addr (fr_wa),
		.wr_data (fr_wd),
		.wr_mask (fr_wm)
	);

	bpa_head_mem u_head_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (hd_ri),
		.rd_data (hd_rd),
		.wr_en   (hd_we),
		.wr_idx  (hd_wi),
		.wr_data (hd_wd)
	);

	assign in_take  = (state_q == bpa_pkg::S_IDLE) && in_valid;
	assign bad_in   = (block_order >= bpa_pkg::ORDER_COUNT) ||
		(migrate_type >= bpa_pkg::TYPE_COUNT);
	assign size_in  = 17'(1) << block_order;
	assign free_bad = ((frame_number & (size_in[bpa_pkg::FRAME_BITS-1:0] - 16'd1)) != 16'd0) ||
		(({1'b0, frame_number} + size_in) > bpa_pkg::NO_FRAME);
	assign high_dn  = high_q - 4'd1;
	assign split_b  = {1'b0, f_q} + (17'(1) << high_dn);
	assign merge_b  = pfn_q ^ (16'(1) << o_q);
	assign found    = hd_rd < bpa_pkg::NO_FRAME;
	assign load_out = (state_q == bpa_pkg::S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::S_CLEAR;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt      = state_q;
		in_stall = (state_q != bpa_pkg::S_IDLE);
		fr_ra    = '0;
		fr_we    = 1'b0;
		fr_wa    = '0;
		fr_wd    = '0;
		fr_wm    = '0;
		hd_ri    = '0;
		hd_we    = 1'b0;
		hd_wi    = '0;
		hd_wd    = '0;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				fr_we      = 1'b1;
				fr_wa      = clr_q;
				fr_wm.free = 1'b1;
				if (clr_q == '1) nxt = bpa_pkg::S_IDLE;
			end
			bpa_pkg::S_IDLE: begin
				if (in_valid) begin
					if (bad_in) nxt = bpa_pkg::S_DONE;
					else if (command == bpa_pkg::CMD_FREE)
						nxt = free_bad ? bpa_pkg::S_DONE : bpa_pkg::S_FREE_RD;
					else nxt = bpa_pkg::S_OWN_RD;
				end
			end
			bpa_pkg::S_FREE_RD: begin
				fr_ra = pfn_q;
				nxt   = bpa_pkg::S_FREE_CHK;
			end
			bpa_pkg::S_FREE_CHK: begin
				nxt = fr_rd.free ? bpa_pkg::S_DONE : bpa_pkg::S_MERGE_RD;
			end
			bpa_pkg::S_OWN_RD: begin
				hd_ri = bpa_pkg::head_index(o_q, typ_q);
				nxt   = bpa_pkg::S_OWN_CHK;
			end
			bpa_pkg::S_OWN_CHK: begin
				if (found) nxt = bpa_pkg::S_UN_RD;
				else if (o_q == bpa_pkg::ORDER_TOP) nxt = bpa_pkg::S_FB_RD;
				else nxt = bpa_pkg::S_OWN_RD;
			end
			bpa_pkg::S_FB_RD: begin
				hd_ri = bpa_pkg::head_index(o_q, bpa_pkg::borrow_type(typ_q, k_q));
				nxt   = bpa_pkg::S_FB_CHK;
			end
			bpa_pkg::S_FB_CHK: begin
				if (found) nxt = bpa_pkg::S_UN_RD;
				else if (!k_q) nxt = bpa_pkg::S_FB_RD;
				else if (o_q == ord_q) nxt = bpa_pkg::S_DONE;
				else nxt = bpa_pkg::S_FB_RD;
			end
			bpa_pkg::S_SPLIT: begin
				if (high_q == ord_q) nxt = bpa_pkg::S_DONE;
				else if (split_b < bpa_pkg::NO_FRAME) nxt = bpa_pkg::S_INS_RD;
			end
			bpa_pkg::S_MERGE_RD: begin
				if (o_q < bpa_pkg::ORDER_TOP) begin
					fr_ra = merge_b;
					nxt   = bpa_pkg::S_MERGE_CHK;
				end else begin
					nxt = bpa_pkg::S_INS_RD;
				end
			end
			bpa_pkg::S_MERGE_CHK: begin
				if (fr_rd.free && fr_rd.order == o_q) nxt = bpa_pkg::S_UN_RD;
				else nxt = bpa_pkg::S_INS_RD;
			end
			bpa_pkg::S_FREE_FIN: begin
				nxt = bpa_pkg::S_DONE;
			end
			bpa_pkg::S_UN_RD: begin
				fr_ra = u_f_q;
				nxt   = bpa_pkg::S_UN_DAT;
			end
			bpa_pkg::S_UN_DAT: begin
				if (fr_rd.prev < bpa_pkg::NO_FRAME) begin
					fr_we      = 1'b1;
					fr_wa      = fr_rd.prev[bpa_pkg::FRAME_BITS-1:0];
					fr_wm.next = 1'b1;
					fr_wd.next = fr_rd.next;
				end else begin
					hd_we = 1'b1;
					hd_wi = bpa_pkg::head_index(fr_rd.order, fr_rd.mtype);
					hd_wd = fr_rd.next;
				end
				nxt = bpa_pkg::S_UN_NEXT;
			end
			bpa_pkg::S_UN_NEXT: begin
				if (u_n_q < bpa_pkg::NO_FRAME) begin
					fr_we      = 1'b1;
					fr_wa      = u_n_q[bpa_pkg::FRAME_BITS-1:0];
					fr_wm.prev = 1'b1;
					fr_wd.prev = u_p_q;
				end
				nxt = bpa_pkg::S_UN_DROP;
			end
			bpa_pkg::S_UN_DROP: begin
				fr_we      = 1'b1;
				fr_wa      = u_f_q;
				fr_wm.free = 1'b1;
				nxt        = ret_u_q;
			end
			bpa_pkg::S_INS_RD: begin
				fr_ra = i_f_q;
				nxt   = bpa_pkg::S_INS_CHK;
			end
			bpa_pkg::S_INS_CHK: begin
				nxt = fr_rd.free ? bpa_pkg::S_UN_RD : bpa_pkg::S_INS_HRD;
			end
			bpa_pkg::S_INS_HRD: begin
				hd_ri = bpa_pkg::head_index(i_o_q, i_t_q);
				nxt   = bpa_pkg::S_INS_HDAT;
			end
			bpa_pkg::S_INS_HDAT: begin
				fr_we = 1'b1;
				fr_wa = i_f_q;
				fr_wm = '1;
				fr_wd = '{free: 1'b1, order: i_o_q, mtype: i_t_q, next: hd_rd,
					prev: bpa_pkg::NO_FRAME};
				nxt   = bpa_pkg::S_INS_LINK;
			end
			bpa_pkg::S_INS_LINK: begin
				if (i_n_q < bpa_pkg::NO_FRAME) begin
					fr_we      = 1'b1;
					fr_wa      = i_n_q[bpa_pkg::FRAME_BITS-1:0];
					fr_wm.prev = 1'b1;
					fr_wd.prev = {1'b0, i_f_q};
				end
				hd_we = 1'b1;
				hd_wi = bpa_pkg::head_index(i_o_q, i_t_q);
				hd_wd = {1'b0, i_f_q};
				nxt   = ret_i_q;
			end
			bpa_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) nxt = bpa_pkg::S_IDLE;
			end
			default: nxt = bpa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_u_q     <= bpa_pkg::S_IDLE;
			ret_i_q     <= bpa_pkg::S_IDLE;
			total_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == bpa_pkg::S_CLEAR) clr_q <= clr_q + 16'd1;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				bpa_pkg::S_OWN_CHK, bpa_pkg::S_FB_CHK: begin
					if (found) ret_u_q <= bpa_pkg::S_SPLIT;
				end
				bpa_pkg::S_SPLIT: begin
					ret_i_q <= bpa_pkg::S_SPLIT;
				end
				bpa_pkg::S_MERGE_RD, bpa_pkg::S_MERGE_CHK: begin
					ret_u_q <= bpa_pkg::S_MERGE_RD;
					ret_i_q <= bpa_pkg::S_FREE_FIN;
				end
				bpa_pkg::S_INS_CHK: begin
					ret_u_q <= bpa_pkg::S_INS_HRD;
				end
				bpa_pkg::S_UN_DROP: begin
					total_q <= total_q - (17'(1) << u_o_q);
				end
				bpa_pkg::S_INS_LINK: begin
					total_q <= total_q + (17'(1) << i_o_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bpa_pkg::S_IDLE: begin
				if (in_take) begin
					ord_q <= block_order;
					typ_q <= migrate_type;
					o_q   <= block_order;
					k_q   <= 1'b0;
					pfn_q <= frame_number;
					rf_q  <= '0;
					ro_q  <= '0;
					if (bad_in || (command == bpa_pkg::CMD_FREE && free_bad)) st_q <= bpa_pkg::ST_BAD;
					else st_q <= bpa_pkg::ST_OK;
				end
			end
			bpa_pkg::S_FREE_CHK: begin
				if (fr_rd.free) st_q <= bpa_pkg::ST_DOUBLE;
			end
			bpa_pkg::S_OWN_CHK: begin
				if (found) begin
					f_q    <= hd_rd[bpa_pkg::FRAME_BITS-1:0];
					u_f_q  <= hd_rd[bpa_pkg::FRAME_BITS-1:0];
					high_q <= o_q;
				end else if (o_q != bpa_pkg::ORDER_TOP) begin
					o_q <= o_q + 4'd1;
				end
			end
			bpa_pkg::S_FB_CHK: begin
				if (found) begin
					f_q    <= hd_rd[bpa_pkg::FRAME_BITS-1:0];
					u_f_q  <= hd_rd[bpa_pkg::FRAME_BITS-1:0];
					high_q <= o_q;
				end else if (!k_q) begin
					k_q <= 1'b1;
				end else if (o_q == ord_q) begin
					st_q <= bpa_pkg::ST_OOM;
				end else begin
					k_q <= 1'b0;
					o_q <= o_q - 4'd1;
				end
			end
			bpa_pkg::S_SPLIT: begin
				if (high_q == ord_q) begin
					rf_q <= f_q;
					ro_q <= ord_q;
				end else begin
					high_q <= high_dn;
					i_f_q  <= split_b[bpa_pkg::FRAME_BITS-1:0];
					i_o_q  <= high_dn;
					i_t_q  <= typ_q;
				end
			end
			bpa_pkg::S_MERGE_RD: begin
				b_q   <= merge_b;
				i_f_q <= pfn_q;
				i_o_q <= o_q;
				i_t_q <= typ_q;
			end
			bpa_pkg::S_MERGE_CHK: begin
				if (fr_rd.free && fr_rd.order == o_q) begin
					u_f_q <= b_q;
					pfn_q <= pfn_q & b_q;
					o_q   <= o_q + 4'd1;
				end
			end
			bpa_pkg::S_FREE_FIN: begin
				rf_q <= pfn_q;
				ro_q <= o_q;
			end
			bpa_pkg::S_UN_DAT: begin
				u_o_q <= fr_rd.order;
				u_n_q <= fr_rd.next;
				u_p_q <= fr_rd.prev;
			end
			bpa_pkg::S_INS_CHK: begin
				if (fr_rd.free) u_f_q <= i_f_q;
			end
			bpa_pkg::S_INS_HDAT: begin
				i_n_q <= hd_rd;
			end
			bpa_pkg::S_DONE: begin
				if (load_out) begin
					status_q       <= st_q;
					result_frame_q <= rf_q;
					result_order_q <= ro_q;
					free_count_q   <= total_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign result_frame    = result_frame_q;
	assign result_order    = result_order_q;
	assign free_page_count = free_count_q;

endmodule

// ===== src/bpa_frame_mem.sv =====
module bpa_frame_mem (
	input  logic                              clk,
	input  logic [bpa_pkg::FRAME_BITS-1:0]    rd_addr,
	output bpa_pkg::frame_word_t              rd_data,
	input  logic                              wr_en,
	input  logic [bpa_pkg::FRAME_BITS-1:0]    wr_addr,
	input  bpa_pkg::frame_word_t              wr_data,
	input  bpa_pkg::frame_mask_t              wr_mask
);

	bpa_pkg::frame_word_t mem [0:(1 << bpa_pkg::FRAME_BITS)-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_mask.free)  mem[wr_addr].free  <= wr_data.free;
			if (wr_mask.order) mem[wr_addr].order <= wr_data.order;
			if (wr_mask.mtype) mem[wr_addr].mtype <= wr_data.mtype;
			if (wr_mask.next)  mem[wr_addr].next  <= wr_data.next;
			if (wr_mask.prev)  mem[wr_addr].prev  <= wr_data.prev;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/bpa_head_mem.sv =====
module bpa_head_mem (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bpa_pkg::HEAD_BITS-1:0]     rd_idx,
	output logic [bpa_pkg::LINK_BITS-1:0]     rd_data,
	input  logic                              wr_en,
	input  logic [bpa_pkg::HEAD_BITS-1:0]     wr_idx,
	input  logic [bpa_pkg::LINK_BITS-1:0]     wr_data
);

	logic [bpa_pkg::LINK_BITS-1:0] mem [0:bpa_pkg::HEAD_COUNT-1];
	logic [bpa_pkg::HEAD_COUNT-1:0] vld_q;
	logic [bpa_pkg::LINK_BITS-1:0] data_q;
	logic                          hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= mem[rd_idx];
		hit_q  <= vld_q[rd_idx];
	end

	assign rd_data = hit_q ? data_q : bpa_pkg::NO_FRAME;

endmodule

// ===== src/bpa_checker.sv =====
`include "buddy_page_allocator_macros.svh"

module bpa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [1:0]                     status,
	input logic [bpa_pkg::FRAME_BITS-1:0] result_frame,
	input logic [bpa_pkg::ORDER_BITS-1:0] result_order
);

	`BPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "Stalled result word dropped.")
	`BPA_ASSERT_SAME(a_fail_zero, out_valid && status != bpa_pkg::ST_OK, result_frame == 16'd0 && result_order == 4'd0, "Failed request reports a block.")
	`BPA_ASSERT_SAME(a_order_range, out_valid && status == bpa_pkg::ST_OK, result_order < bpa_pkg::ORDER_COUNT, "Result order out of range.")
	`BPA_ASSERT_SAME(a_aligned, out_valid && status == bpa_pkg::ST_OK, (result_frame & ((16'd1 << result_order) - 16'd1)) == 16'd0, "Result block is misaligned.")
	`BPA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "Second word taken while one is in work.")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
